FILE: rtl/spadd_pkg.sv
package spadd_pkg;

  localparam int unsigned CoefBits  = 16;
  localparam int unsigned SumBits   = 17;
  localparam int unsigned ExponBits = 10;

  // request modes
  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_START  = 2'd2;

  typedef struct packed {
    logic [1:0]                  mode;
    logic signed [CoefBits-1:0]  term_coef;
    logic [ExponBits-1:0]        term_expon;
  } in_req_t;

  typedef struct packed {
    logic signed [SumBits-1:0]   sum_coef;
    logic [ExponBits-1:0]        sum_expon;
    logic                        last_term;
    logic                        empty_sum;
  } out_rsp_t;

  // one stored term
  typedef struct packed {
    logic signed [CoefBits-1:0]  coef;
    logic [ExponBits-1:0]        expon;
  } term_t;

  // decision of one merge step
  typedef struct packed {
    logic                        take_a;
    logic                        take_b;
    logic                        emit;
    logic                        done;
    logic signed [SumBits-1:0]   coef;
    logic [ExponBits-1:0]        expon;
  } step_t;

endpackage

FILE: rtl/spadd_merge_alu.sv
module spadd_merge_alu (
  input  spadd_pkg::term_t a_term_i,
  input  spadd_pkg::term_t b_term_i,
  input  logic             a_avail_i,
  input  logic             b_avail_i,
  output spadd_pkg::step_t step_o
);
  import spadd_pkg::*;

  logic signed [SumBits-1:0] a_ext;
  logic signed [SumBits-1:0] b_ext;
  logic signed [SumBits-1:0] sum;

  assign a_ext = {a_term_i.coef[CoefBits-1], a_term_i.coef};
  assign b_ext = {b_term_i.coef[CoefBits-1], b_term_i.coef};
  assign sum   = a_ext + b_ext;

  always_comb begin
    step_o = '0;
    if (a_avail_i && b_avail_i) begin
      if (a_term_i.expon < b_term_i.expon) begin
        step_o.take_b = 1'b1;
        step_o.emit   = 1'b1;
        step_o.coef   = b_ext;
        step_o.expon  = b_term_i.expon;
      end else if (a_term_i.expon > b_term_i.expon) begin
        step_o.take_a = 1'b1;
        step_o.emit   = 1'b1;
        step_o.coef   = a_ext;
        step_o.expon  = a_term_i.expon;
      end else begin
        // equal exponents: add, drop a zero sum
        step_o.take_a = 1'b1;
        step_o.take_b = 1'b1;
        step_o.emit   = (sum != '0);
        step_o.coef   = sum;
        step_o.expon  = a_term_i.expon;
      end
    end else if (a_avail_i) begin
      step_o.take_a = 1'b1;
      step_o.emit   = 1'b1;
      step_o.coef   = a_ext;
      step_o.expon  = a_term_i.expon;
    end else if (b_avail_i) begin
      step_o.take_b = 1'b1;
      step_o.emit   = 1'b1;
      step_o.coef   = b_ext;
      step_o.expon  = b_term_i.expon;
    end else begin
      step_o.done = 1'b1;
    end
  end

endmodule

FILE: rtl/sparse_poly_add_merge_core.sv
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+----------------------------
// in       | input     | in_valid_i / in_ready_o | in_req_i  (mode, coef, expon)
// out      | output    | out_valid_o/out_ready_i | out_rsp_o (coef, expon, marks)
//
// a load request gives no result
// a start request walks both term stores; each merge step is a store read
// (ST_READ), then compare/add in the shared unit (ST_EVAL)
// the registered store read is why each step needs its own read state
// the merge stalls while the output register holds a result not yet taken
// reset clears the counts and the sequencer; the stores are not cleared
module sparse_poly_add_merge_core #(
  parameter int unsigned MAX_TERMS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  spadd_pkg::in_req_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output spadd_pkg::out_rsp_t out_rsp_o
);
  import spadd_pkg::*;

  localparam int unsigned AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CW = $clog2(MAX_TERMS + 1);
  localparam logic [CW-1:0] FullCnt = CW'(MAX_TERMS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } state_e;

  state_e state_q;

  // term stores
  term_t a_mem [MAX_TERMS];
  term_t b_mem [MAX_TERMS];
  term_t a_rd_q;
  term_t b_rd_q;

  logic [CW-1:0] a_cnt_q, b_cnt_q;
  logic [CW-1:0] a_idx_q, b_idx_q;

  // held result term, sent once the next one (or the end) is known
  logic                      pend_v_q;
  logic signed [SumBits-1:0] pend_coef_q;
  logic [ExponBits-1:0]      pend_expon_q;

  logic     out_valid_q;
  out_rsp_t out_q;

  logic  accept;
  logic  load_a, load_b;
  logic  out_free;
  logic  out_load;
  step_t step;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign load_a      = accept && (in_req_i.mode == MODE_LOAD_A) && (a_cnt_q != FullCnt);
  assign load_b      = accept && (in_req_i.mode == MODE_LOAD_B) && (b_cnt_q != FullCnt);
  assign out_free    = !out_valid_q || out_ready_i;
  // output register takes a new result: the final flush, or a held term pushed out
  assign out_load    = (state_q == ST_EVAL) && out_free &&
                       (step.done || (step.emit && pend_v_q));
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // store write at the fill count, registered read at the merge pointer
  always_ff @(posedge clk_i) begin
    if (load_a) begin
      a_mem[a_cnt_q[AW-1:0]] <= '{coef: in_req_i.term_coef, expon: in_req_i.term_expon};
    end
    if (load_b) begin
      b_mem[b_cnt_q[AW-1:0]] <= '{coef: in_req_i.term_coef, expon: in_req_i.term_expon};
    end
    a_rd_q <= a_mem[a_idx_q[AW-1:0]];
    b_rd_q <= b_mem[b_idx_q[AW-1:0]];
  end

  // shared compare / add unit
  spadd_merge_alu u_alu (
    .a_term_i  (a_rd_q),
    .b_term_i  (b_rd_q),
    .a_avail_i (a_idx_q < a_cnt_q),
    .b_avail_i (b_idx_q < b_cnt_q),
    .step_o    (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      a_cnt_q      <= '0;
      b_cnt_q      <= '0;
      a_idx_q      <= '0;
      b_idx_q      <= '0;
      pend_v_q     <= 1'b0;
      pend_coef_q  <= '0;
      pend_expon_q <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_req_i.mode)
              MODE_LOAD_A: begin
                if (load_a) begin
                  a_cnt_q <= a_cnt_q + 1'b1;
                end
              end
              MODE_LOAD_B: begin
                if (load_b) begin
                  b_cnt_q <= b_cnt_q + 1'b1;
                end
              end
              MODE_START: begin
                a_idx_q  <= '0;
                b_idx_q  <= '0;
                pend_v_q <= 1'b0;
                state_q  <= ST_READ;
              end
              default: begin
                // unused mode, ignored
              end
            endcase
          end
        end
        ST_READ: begin
          // read data lands in a_rd_q / b_rd_q
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          if (out_free) begin
            if (step.done) begin
              // flush the held term with the last mark, or report an empty sum
              if (pend_v_q) begin
                out_q <= '{sum_coef: pend_coef_q, sum_expon: pend_expon_q,
                           last_term: 1'b1, empty_sum: 1'b0};
              end else begin
                out_q <= '{sum_coef: '0, sum_expon: '0,
                           last_term: 1'b1, empty_sum: 1'b1};
              end
              pend_v_q <= 1'b0;
              a_cnt_q  <= '0;
              b_cnt_q  <= '0;
              state_q  <= ST_IDLE;
            end else begin
              if (step.take_a) begin
                a_idx_q <= a_idx_q + 1'b1;
              end
              if (step.take_b) begin
                b_idx_q <= b_idx_q + 1'b1;
              end
              if (step.emit) begin
                if (pend_v_q) begin
                  out_q <= '{sum_coef: pend_coef_q, sum_expon: pend_expon_q,
                             last_term: 1'b0, empty_sum: 1'b0};
                end
                pend_v_q     <= 1'b1;
                pend_coef_q  <= step.coef;
                pend_expon_q <= step.expon;
              end
              state_q <= ST_READ;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // an empty-sum item is the only item of its addition and carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.empty_sum |->
      out_rsp_o.last_term && (out_rsp_o.sum_coef == '0) && (out_rsp_o.sum_expon == '0))
    else $error("empty sum item malformed");

  // fill counts never pass capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_cnt_q <= FullCnt) && (b_cnt_q <= FullCnt))
    else $error("store count beyond capacity");

  // merge pointers never run past the fill counts while merging
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (a_idx_q <= a_cnt_q) && (b_idx_q <= b_cnt_q))
    else $error("merge pointer past store count");

  // finishing a merge clears both fill counts and sends a last item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) && out_free && step.done |=>
      (a_cnt_q == '0) && (b_cnt_q == '0) && out_valid_o && out_rsp_o.last_term)
    else $error("merge end did not clear stores");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import spadd_pkg::*;

  localparam int unsigned MaxTerms  = 32;
  localparam int          RandItems = 230;
  // mode 3 has no meaning for the block, it must be ignored
  localparam logic [1:0]  ModeUnused = 2'd3;
  // receiver blackout, long enough to back the merge up into the input
  localparam int          HoldAt     = 120;
  localparam int          HoldCycles = 300;
  // give the worst merge plenty of room at the end
  localparam int          DrainCycles = 200;
  localparam int          QuietLimit  = 3000;

  // one entry of the stimulus queue: a request, or a pause marker that makes
  // the sender wait until every expected term has come out, bar the blackout
  typedef struct packed {
    logic    pause;
    in_req_t req;
  } stim_t;

  logic     clk_i      = 1'b0;
  logic     rst_ni     = 1'b0;
  logic     in_valid   = 1'b0;
  in_req_t  in_req     = '0;
  logic     out_ready  = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  out_rsp_t out_rsp_o;

  stim_t    pend_q[$];
  out_rsp_t sum_terms_q[$];

  // predictor copy of both term stores
  term_t    poly_a[MaxTerms];
  term_t    poly_b[MaxTerms];
  int       a_len = 0;
  int       b_len = 0;

  int       errors    = 0;
  int       gen_cnt   = 0;
  int       sent_cnt  = 0;
  bit       calm      = 1'b0;
  int       in_gap    = 0;
  int       in_pct    = 0;
  int       in_left   = 0;
  bit       in_idle;
  int       out_gap   = 0;
  int       out_pct   = 0;
  int       out_left  = 0;
  bit       out_idle;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  int       quiet     = 0;

  sparse_poly_add_merge_core #(
    .MAX_TERMS (MaxTerms)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic flag_mismatch(input string what, input int got, input int want);
    errors++;
    // keep the log short when the block is badly off
    if (errors <= 50) begin
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
    end
  endtask

  // ---------------------------------------------------------------------------
  // term-sum predictor
  // ---------------------------------------------------------------------------

  function automatic out_rsp_t term_rsp(input logic signed [SumBits-1:0] coef,
                                        input logic [ExponBits-1:0] expon);
    out_rsp_t r;
    r = '0;
    r.sum_coef  = coef;
    r.sum_expon = expon;
    return r;
  endfunction

  // merge both stores by exponent, highest first, and queue the sum terms
  task automatic add_polys();
    out_rsp_t                  res[2*MaxTerms];
    int                        n;
    int                        i;
    int                        j;
    logic signed [SumBits-1:0] ca;
    logic signed [SumBits-1:0] cb;
    n = 0;
    i = 0;
    j = 0;
    while (i < a_len && j < b_len) begin
      ca = $signed(poly_a[i].coef);
      cb = $signed(poly_b[j].coef);
      if (poly_a[i].expon < poly_b[j].expon) begin
        res[n] = term_rsp(cb, poly_b[j].expon);
        n++;
        j++;
      end else if (poly_a[i].expon > poly_b[j].expon) begin
        res[n] = term_rsp(ca, poly_a[i].expon);
        n++;
        i++;
      end else begin
        // equal exponents add up, a zero sum vanishes
        if (ca + cb != 0) begin
          res[n] = term_rsp(ca + cb, poly_a[i].expon);
          n++;
        end
        i++;
        j++;
      end
    end
    while (i < a_len) begin
      res[n] = term_rsp($signed(poly_a[i].coef), poly_a[i].expon);
      n++;
      i++;
    end
    while (j < b_len) begin
      res[n] = term_rsp($signed(poly_b[j].coef), poly_b[j].expon);
      n++;
      j++;
    end
    // nothing survived: a single empty marker item
    if (n == 0) begin
      res[0] = term_rsp('0, '0);
      res[0].empty_sum = 1'b1;
      n = 1;
    end
    res[n-1].last_term = 1'b1;
    for (int k = 0; k < n; k++) begin
      sum_terms_q.push_back(res[k]);
    end
    // start empties both stores
    a_len = 0;
    b_len = 0;
  endtask

  task automatic predict_request(input in_req_t r);
    case (r.mode)
      MODE_LOAD_A: begin
        // a full store drops the load
        if (a_len < MaxTerms) begin
          poly_a[a_len].coef  = r.term_coef;
          poly_a[a_len].expon = r.term_expon;
          a_len++;
        end
      end
      MODE_LOAD_B: begin
        if (b_len < MaxTerms) begin
          poly_b[b_len].coef  = r.term_coef;
          poly_b[b_len].expon = r.term_expon;
          b_len++;
        end
      end
      MODE_START: add_polys();
      default: ;
    endcase
  endtask

  task automatic check_result(input out_rsp_t got);
    out_rsp_t want;
    if (sum_terms_q.size() == 0) begin
      flag_mismatch("result term with none expected", $signed(got.sum_coef), 0);
      return;
    end
    want = sum_terms_q.pop_front();
    if (got.sum_coef !== want.sum_coef)
      flag_mismatch("sum_coef", $signed(got.sum_coef), $signed(want.sum_coef));
    if (got.sum_expon !== want.sum_expon)
      flag_mismatch("sum_expon", got.sum_expon, want.sum_expon);
    if (got.last_term !== want.last_term)
      flag_mismatch("last_term", got.last_term, want.last_term);
    if (got.empty_sum !== want.empty_sum)
      flag_mismatch("empty_sum", got.empty_sum, want.empty_sum);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  task automatic push_req(input logic [1:0] mode, input logic signed [CoefBits-1:0] coef,
                          input logic [ExponBits-1:0] expon);
    stim_t s;
    s.pause          = 1'b0;
    s.req.mode       = mode;
    s.req.term_coef  = coef;
    s.req.term_expon = expon;
    pend_q.push_back(s);
    if (mode != ModeUnused) gen_cnt++;
  endtask

  task automatic push_pause();
    stim_t s;
    s       = '0;
    s.pause = 1'b1;
    pend_q.push_back(s);
  endtask

  function automatic logic signed [CoefBits-1:0] rand_coef();
    int v;
    v = int'($urandom_range(0, 20)) - 10;
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CoefBits'(v);
      2:       return 16'sh7fff;
      3:       return 16'sh8000;
      default: return CoefBits'($urandom);
    endcase
  endfunction

  // one well-formed addition: na terms of A and nb terms of B, each in
  // descending exponent order, with many shared exponents (some cancelling),
  // loads of the two stores interleaved at random, then a start
  task automatic queue_sum_case(input int na, input int nb);
    term_t                       ta[$];
    term_t                       tb[$];
    term_t                       t;
    int                          e;
    int                          stepmax;
    int                          kind;
    int                          ia;
    int                          ib;
    logic signed [CoefBits-1:0]  c;
    e       = ($urandom_range(0, 3) == 0) ? 1023 : 1023 - int'($urandom_range(0, 30));
    stepmax = 900 / (na + nb + 1);
    if (stepmax < 1) stepmax = 1;
    while ((ta.size() < na || tb.size() < nb) && e >= 0) begin
      kind = $urandom_range(0, 2);
      if (ta.size() >= na) kind = 1;
      else if (tb.size() >= nb) kind = 0;
      c       = rand_coef();
      t.expon = ExponBits'(e);
      if (kind != 1) begin
        t.coef = c;
        ta.push_back(t);
      end
      if (kind != 0) begin
        // B term; on a shared exponent often the exact negative so the term cancels
        t.coef = (kind == 2 && $urandom_range(0, 1) == 1) ? -c : rand_coef();
        tb.push_back(t);
      end
      e -= $urandom_range(1, stepmax);
    end
    ia = 0;
    ib = 0;
    while (ia < ta.size() || ib < tb.size()) begin
      if (ib >= tb.size() || (ia < ta.size() && $urandom_range(0, 1) == 1)) begin
        push_req(MODE_LOAD_A, ta[ia].coef, ta[ia].expon);
        ia++;
      end else begin
        push_req(MODE_LOAD_B, tb[ib].coef, tb[ib].expon);
        ib++;
      end
    end
    push_req(MODE_START, rand_coef(), ExponBits'($urandom));
  endtask

  // idling comes in stretches: each stretch picks how often gaps open,
  // zero included, so there are also runs with no gaps at all
  task automatic roll_idle(inout int pct, inout int left, output bit idle_now);
    if (left == 0) begin
      left = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0:       pct = 0;
        1:       pct = 10;
        default: pct = 35;
      endcase
    end
    left--;
    idle_now = (int'($urandom_range(0, 99)) < pct);
  endtask

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_req   <= '0;
    end else begin
      // request taken at this edge: predict what it causes
      if (in_valid && in_ready_o) begin
        predict_request(in_req);
        sent_cnt++;
      end
      // no idling on either side near the end of the run
      calm = (pend_q.size() < 40);
      if (in_valid && !in_ready_o) begin
        // stalled: keep the request as it is
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pend_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pend_q[0].pause) begin
        // hold off until every expected term has been delivered; during the
        // receiver blackout the sender keeps going so the block backs up
        in_valid <= 1'b0;
        if (sum_terms_q.size() == 0 || hold_left > 0) void'(pend_q.pop_front());
      end else begin
        roll_idle(in_pct, in_left, in_idle);
        if (!calm && in_idle) begin
          in_gap = $urandom_range(0, 13);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_req   <= pend_q[0].req;
          void'(pend_q.pop_front());
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and receiver
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) check_result(out_rsp_o);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && sent_cnt >= HoldAt) begin
        // one long blackout while the sender keeps going, so the merge
        // backs up and the block has to stall its input
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        roll_idle(out_pct, out_left, out_idle);
        if (!calm && out_idle) begin
          out_gap = $urandom_range(0, 13);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // watchdog: too long without any handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) quiet = 0;
    else quiet++;
    if (quiet >= QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    // nothing loaded yet: start must give the empty marker
    push_req(MODE_START, 0, 0);
    push_req(ModeUnused, -1, 1023);
    // coefficient extremes at exponents 1023 and 512, a cancelling pair,
    // a lone zero coefficient that must still come out
    push_req(MODE_LOAD_A, 32767, 1023);
    push_req(MODE_LOAD_B, 32767, 1023);
    push_req(MODE_LOAD_A, -32768, 512);
    push_req(MODE_LOAD_B, -32768, 512);
    push_req(MODE_LOAD_A, 1, 300);
    push_req(MODE_LOAD_B, -1, 300);
    push_req(MODE_LOAD_B, 5, 100);
    push_req(ModeUnused, 0, 0);
    push_req(MODE_LOAD_A, 0, 0);
    push_req(MODE_START, -1, 1023);
    // everything cancels
    push_req(MODE_LOAD_A, 100, 5);
    push_req(MODE_LOAD_B, -100, 5);
    push_req(MODE_START, 0, 0);
    // store A loaded out of order
    push_req(MODE_LOAD_A, 1, 3);
    push_req(MODE_LOAD_A, 2, 9);
    push_req(MODE_LOAD_B, 4, 6);
    push_req(MODE_START, 0, 0);
    // only one store holds terms
    push_req(MODE_LOAD_B, 7, 1023);
    push_req(MODE_START, 0, 0);
    push_req(MODE_LOAD_A, -7, 0);
    push_req(MODE_START, 0, 0);
    push_pause();

    // random part: both stores overfilled once, then mostly small sums
    queue_sum_case(34, $urandom_range(0, 6));
    queue_sum_case($urandom_range(0, 6), 33);
    while (gen_cnt < RandItems) begin
      if ($urandom_range(0, 9) == 0) push_pause();
      if ($urandom_range(0, 7) == 0) begin
        // noise: any mode, loads in any order, unused mode too
        repeat ($urandom_range(1, 5)) begin
          push_req(2'($urandom_range(0, 3)), CoefBits'($urandom), ExponBits'($urandom));
        end
      end else begin
        queue_sum_case($urandom_range(0, 8), $urandom_range(0, 8));
      end
    end
    // flush whatever noise left in the stores
    push_req(MODE_START, 0, 0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pend_q.size() != 0 || in_valid || sum_terms_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sum_terms_q.size() != 0)
      flag_mismatch("result terms never delivered", sum_terms_q.size(), 0);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
